// ===== rtl/tpp_pkg.sv =====
`default_nettype none
package tpp_pkg;

  localparam int unsigned TAPE_BYTES = 262144;
  localparam int unsigned ADDR_W     = $clog2(TAPE_BYTES);
  localparam int unsigned LEN_W      = 19;
  localparam int unsigned CNT_W      = 24;
  localparam int unsigned CYC_W      = 40;
  localparam int unsigned SEC_W      = 16;
  localparam int unsigned CFG_W      = 24;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned DIV_CNT_W  = $clog2(CYC_W);

  localparam logic [LEN_W-1:0]     TAPE_LEN   = LEN_W'(TAPE_BYTES);
  localparam logic [CFG_W-1:0]     CPS_RESET  = CFG_W'(985248);
  localparam logic [CNT_W-1:0]     ZERO_PULSE = CNT_W'(2048);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST   = DIV_CNT_W'(CYC_W - 1);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_VERSION = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CPS     = 1'b1;

  // func codes on the input beat
  localparam logic [2:0] FUNC_TICK   = 3'd0;
  localparam logic [2:0] FUNC_LOAD   = 3'd1;
  localparam logic [2:0] FUNC_CLEAR  = 3'd2;
  localparam logic [2:0] FUNC_REWIND = 3'd3;
  localparam logic [2:0] FUNC_PLAY   = 3'd4;
  localparam logic [2:0] FUNC_STOP   = 3'd5;
  localparam logic [2:0] FUNC_MOTOR  = 3'd6;

  typedef enum logic [2:0] {
    OP_TICK, OP_LOAD, OP_CLEAR, OP_REWIND, OP_PLAY, OP_STOP, OP_MOTOR, OP_NONE
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] tbyte;
    logic       motor;
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_FETCH, ST_GOT, ST_APPLY, ST_DIVGO, ST_DIV, ST_OUT
  } state_e;

  typedef struct packed {
    logic             we;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0] data;
  } cfg_t;

  typedef struct packed {
    logic             full;
    logic             stopped;
    logic             playing;
    logic             changed;
    logic [SEC_W-1:0] secs;
    logic [LEN_W-1:0] head;
    logic             fall;
    logic             rise;
  } result_t;

endpackage
`default_nettype wire

// ===== rtl/tpp_ram.sv =====
`default_nettype none
module tpp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

// ===== rtl/tpp_front.sv =====
`default_nettype none
module tpp_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  output logic               ready_o,
  input  wire logic [2:0]    func_i,
  input  wire logic [7:0]    tbyte_i,
  input  wire logic          motor_i,
  output logic               item_valid_o,
  output tpp_pkg::item_t     item_o,
  input  wire logic          pop_i
);

  tpp_pkg::item_t slot_q [2];
  tpp_pkg::item_t cls;
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  // classify the func code
  always_comb begin
    cls.tbyte = tbyte_i;
    cls.motor = motor_i;
    unique case (func_i)
      tpp_pkg::FUNC_TICK:   cls.op = tpp_pkg::OP_TICK;
      tpp_pkg::FUNC_LOAD:   cls.op = tpp_pkg::OP_LOAD;
      tpp_pkg::FUNC_CLEAR:  cls.op = tpp_pkg::OP_CLEAR;
      tpp_pkg::FUNC_REWIND: cls.op = tpp_pkg::OP_REWIND;
      tpp_pkg::FUNC_PLAY:   cls.op = tpp_pkg::OP_PLAY;
      tpp_pkg::FUNC_STOP:   cls.op = tpp_pkg::OP_STOP;
      tpp_pkg::FUNC_MOTOR:  cls.op = tpp_pkg::OP_MOTOR;
      default:              cls.op = tpp_pkg::OP_NONE;
    endcase
  end

  assign ready_o      = (cnt_q != 2'd2);
  assign item_valid_o = (cnt_q != 2'd0);
  assign item_o       = slot_q[rd_q];
  assign push         = valid_i && ready_o;
  assign pop          = pop_i && item_valid_o;

  always_comb begin
    wr_d  = push ? ~wr_q : wr_q;
    rd_d  = pop ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= cls;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/tpp_div.sv =====
`default_nettype none
module tpp_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [tpp_pkg::CYC_W-1:0]   dividend_i,
  input  wire logic [tpp_pkg::CFG_W-1:0]   divisor_i,
  output logic                             done_o,
  output logic      [tpp_pkg::SEC_W-1:0]   secs_o
);

  logic                            busy_q, busy_d, done_q, done_d;
  logic [tpp_pkg::DIV_CNT_W-1:0]   cnt_q, cnt_d;
  logic [tpp_pkg::CYC_W-1:0]       dvd_q, dvd_d, quo_q, quo_d;
  logic [tpp_pkg::CFG_W-1:0]       dvs_q, dvs_d;
  logic [tpp_pkg::CFG_W:0]         rem_q, rem_d, rem_sh;
  logic                            fits;

  // one restoring step per cycle, quotient bit by bit
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    rem_sh = {rem_q[tpp_pkg::CFG_W-1:0], dvd_q[tpp_pkg::CYC_W-1]};
    fits   = (rem_sh >= {1'b0, dvs_q});
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = dividend_i;
      quo_d  = '0;
      rem_d  = '0;
      dvs_d  = (divisor_i == '0) ? tpp_pkg::CFG_W'(1) : divisor_i;
    end else if (busy_q) begin
      rem_d = fits ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
      quo_d = {quo_q[tpp_pkg::CYC_W-2:0], fits};
      dvd_d = {dvd_q[tpp_pkg::CYC_W-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == tpp_pkg::DIV_LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  // saturate the whole seconds
  assign done_o = done_q;
  assign secs_o = (quo_q[tpp_pkg::CYC_W-1:tpp_pkg::SEC_W] != '0) ? '1
                : quo_q[tpp_pkg::SEC_W-1:0];

endmodule
`default_nettype wire

// ===== rtl/tpp_back.sv =====
`default_nettype none
module tpp_back (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  tpp_pkg::cfg_t                    cfg_i,
  input  wire logic                        item_valid_i,
  input  tpp_pkg::item_t                   item_i,
  output logic                             pop_o,
  output logic                             out_valid_o,
  output tpp_pkg::result_t                 out_o,
  input  wire logic                        out_ready_i
);

  localparam int unsigned AW = tpp_pkg::ADDR_W;
  localparam int unsigned LW = tpp_pkg::LEN_W;
  localparam int unsigned CW = tpp_pkg::CNT_W;
  localparam logic [CW-1:0] ZERO_LEN = tpp_pkg::ZERO_PULSE;

  tpp_pkg::state_e state_q, state_d;

  logic [LW-1:0]             length_q, length_d, head_q, head_d;
  logic [tpp_pkg::CYC_W-1:0] cycles_q, cycles_d;
  logic [tpp_pkg::SEC_W-1:0] secs_q, secs_d, before_q, before_d;
  logic [CW-1:0]             rise_q, rise_d, fall_q, fall_d, len_q, len_d;
  logic                      play_q, play_d, motor_q, motor_d;
  logic                      ver_q, ver_d;
  logic [tpp_pkg::CFG_W-1:0] cps_q, cps_d;
  logic [1:0]                idx_q, idx_d;
  logic                      four_q, four_d;
  logic                      rf_q, rf_d, ff_q, ff_d, sf_q, sf_d, full_q, full_d;
  logic                      ov_q, ov_d;
  tpp_pkg::result_t          res_q, res_d;

  logic          mem_we;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;
  logic          div_start, div_done;
  logic [tpp_pkg::SEC_W-1:0] div_secs;
  logic [CW-1:0] rise_dec, fall_dec;
  logic          has_more;

  tpp_ram #(
    .WIDTH (8),
    .DEPTH (tpp_pkg::TAPE_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (length_q[AW-1:0]),
    .wdata_i (item_i.tbyte),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  tpp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (cycles_q),
    .divisor_i  (cps_q),
    .done_o     (div_done),
    .secs_o     (div_secs)
  );

  assign mem_raddr = AW'(head_q + LW'(idx_q));
  assign rise_dec  = rise_q - 1'b1;
  assign fall_dec  = fall_q - 1'b1;
  assign has_more  = ({1'b0, head_q} + (LW+1)'(3)) < {1'b0, length_q};

  always_comb begin
    state_d  = state_q;
    length_d = length_q;
    head_d   = head_q;
    cycles_d = cycles_q;
    secs_d   = secs_q;
    before_d = before_q;
    rise_d   = rise_q;
    fall_d   = fall_q;
    len_d    = len_q;
    play_d   = play_q;
    motor_d  = motor_q;
    ver_d    = ver_q;
    cps_d    = cps_q;
    idx_d    = idx_q;
    four_d   = four_q;
    rf_d     = rf_q;
    ff_d     = ff_q;
    sf_d     = sf_q;
    full_d   = full_q;
    ov_d     = ov_q;
    res_d    = res_q;
    pop_o    = 1'b0;
    mem_we   = 1'b0;
    div_start = 1'b0;

    if (cfg_i.we) begin
      unique case (cfg_i.idx)
        tpp_pkg::REG_VERSION: ver_d = cfg_i.data[0];
        tpp_pkg::REG_CPS:     cps_d = cfg_i.data;
        default: ;
      endcase
    end

    if (ov_q && out_ready_i) begin
      ov_d = 1'b0;
    end

    unique case (state_q)
      tpp_pkg::ST_IDLE: begin
        if (item_valid_i) begin
          pop_o    = 1'b1;
          before_d = secs_q;
          rf_d     = 1'b0;
          ff_d     = 1'b0;
          sf_d     = 1'b0;
          full_d   = 1'b0;
          idx_d    = 2'd0;
          state_d  = tpp_pkg::ST_OUT;
          case (item_i.op)
            tpp_pkg::OP_TICK: begin
              if (length_q != '0 && play_q && motor_q) begin
                rise_d = rise_dec;
                fall_d = fall_dec;
                rf_d   = (rise_dec == '0);
                if (fall_dec == '0) begin
                  ff_d = 1'b1;
                  if (head_q < length_q) begin
                    state_d = tpp_pkg::ST_FETCH;
                  end else begin
                    play_d  = 1'b0;
                    motor_d = 1'b0;
                    sf_d    = 1'b1;
                  end
                end
              end
            end
            tpp_pkg::OP_LOAD: begin
              if (length_q < tpp_pkg::TAPE_LEN) begin
                mem_we   = 1'b1;
                length_d = length_q + 1'b1;
              end else begin
                full_d = 1'b1;
              end
            end
            tpp_pkg::OP_CLEAR: begin
              play_d   = 1'b0;
              motor_d  = 1'b0;
              length_d = '0;
              head_d   = '0;
              cycles_d = '0;
              secs_d   = '0;
              rise_d   = '0;
              fall_d   = '0;
            end
            tpp_pkg::OP_REWIND: begin
              head_d   = '0;
              cycles_d = '0;
              secs_d   = '0;
            end
            tpp_pkg::OP_PLAY: begin
              if (length_q != '0 && head_q < length_q) begin
                play_d  = 1'b1;
                state_d = tpp_pkg::ST_FETCH;
              end
            end
            tpp_pkg::OP_STOP: begin
              play_d  = 1'b0;
              motor_d = 1'b0;
            end
            tpp_pkg::OP_MOTOR: motor_d = item_i.motor;
            default: ;
          endcase
        end
      end
      tpp_pkg::ST_FETCH: state_d = tpp_pkg::ST_GOT;
      tpp_pkg::ST_GOT: begin
        if (idx_q == 2'd0) begin
          four_d = 1'b0;
          len_d  = ZERO_LEN;
          state_d = tpp_pkg::ST_APPLY;
          if (mem_rdata != 8'd0) begin
            len_d = CW'({mem_rdata, 3'b000});
          end else if (ver_q) begin
            four_d = 1'b1;
            if (has_more) begin
              idx_d   = 2'd1;
              state_d = tpp_pkg::ST_FETCH;
            end
          end
        end else begin
          case (idx_q)
            2'd1:    len_d[7:0]   = mem_rdata;
            2'd2:    len_d[15:8]  = mem_rdata;
            default: len_d[23:16] = mem_rdata;
          endcase
          if (idx_q == 2'd3) begin
            state_d = tpp_pkg::ST_APPLY;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = tpp_pkg::ST_FETCH;
          end
        end
      end
      tpp_pkg::ST_APPLY: begin
        rise_d   = len_q >> 1;
        fall_d   = len_q;
        head_d   = head_q + (four_q ? LW'(4) : LW'(1));
        cycles_d = cycles_q + tpp_pkg::CYC_W'(len_q);
        state_d  = tpp_pkg::ST_DIVGO;
      end
      tpp_pkg::ST_DIVGO: begin
        div_start = 1'b1;
        state_d   = tpp_pkg::ST_DIV;
      end
      tpp_pkg::ST_DIV: begin
        if (div_done) begin
          secs_d  = div_secs;
          state_d = tpp_pkg::ST_OUT;
        end
      end
      tpp_pkg::ST_OUT: begin
        if (!ov_q || out_ready_i) begin
          ov_d          = 1'b1;
          res_d.rise    = rf_q;
          res_d.fall    = ff_q;
          res_d.head    = head_q;
          res_d.secs    = secs_q;
          res_d.changed = (secs_q != before_q);
          res_d.playing = play_q;
          res_d.stopped = sf_q;
          res_d.full    = full_q;
          state_d       = tpp_pkg::ST_IDLE;
        end
      end
      default: state_d = tpp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= tpp_pkg::ST_IDLE;
      length_q <= '0;
      head_q   <= '0;
      cycles_q <= '0;
      secs_q   <= '0;
      rise_q   <= '0;
      fall_q   <= '0;
      play_q   <= 1'b0;
      motor_q  <= 1'b0;
      ver_q    <= 1'b0;
      cps_q    <= tpp_pkg::CPS_RESET;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      length_q <= length_d;
      head_q   <= head_d;
      cycles_q <= cycles_d;
      secs_q   <= secs_d;
      rise_q   <= rise_d;
      fall_q   <= fall_d;
      play_q   <= play_d;
      motor_q  <= motor_d;
      ver_q    <= ver_d;
      cps_q    <= cps_d;
      ov_q     <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    before_q <= before_d;
    len_q    <= len_d;
    idx_q    <= idx_d;
    four_q   <= four_d;
    rf_q     <= rf_d;
    ff_q     <= ff_d;
    sf_q     <= sf_d;
    full_q   <= full_d;
    res_q    <= res_d;
  end

  assign out_valid_o = ov_q;
  assign out_o       = res_q;

endmodule
`default_nettype wire

// ===== rtl/tape_pulse_playback.sv =====
`default_nettype none
// Cassette tape pulse playback.
//
// Input channel s_axis_*: one beat per command (tick, load byte, clear tape,
// rewind, play, stop, set motor). Output channel m_axis_*: exactly one result
// beat per input beat, in order, carrying the edge flags, head offset, tape
// seconds and play status.
// Config port: cfg_we_i writes cfg_data_i to register cfg_idx_i
// (0 tape version, 1 machine cycles per second); write only while idle.
//
// A two-entry queue takes input beats and classifies them; the executor
// handles one command at a time. Plain commands and ticks inside a pulse
// go from the dequeue step straight to the result register. A play or a
// tick that ends a pulse reads the tape store (fetch, then capture, for
// each of up to 4 bytes), then runs a 40-step radix-2 divider for the
// seconds count before the result register is written. A new command is
// dequeued only after the result of the last one is registered.
//
// Reset clears the tape and play state, sets the cycles-per-second register
// to 985248; the tape store is not cleared and needs no sweep. When the
// receiver stalls, the result is held in the output register, the executor
// parks with its next result, and the queue fills and then deasserts tready.
module tape_pulse_playback (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // func[2:0], tape_byte[10:3], motor_on[11]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // rising_edge[0], falling_edge[1], head_position[20:2], tape_seconds[36:21],
  // seconds_changed[37], playing[38], auto_stopped[39], store_full[40]
  output logic      [47:0] m_axis_tdata,
  input  wire logic        cfg_we_i,
  input  wire logic [tpp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [tpp_pkg::CFG_W-1:0]     cfg_data_i
);

  tpp_pkg::item_t   item;
  tpp_pkg::result_t res;
  tpp_pkg::cfg_t    cfg;
  logic             item_valid, pop;

  assign cfg.we   = cfg_we_i;
  assign cfg.idx  = cfg_idx_i;
  assign cfg.data = cfg_data_i;

  // accept and classify beats
  tpp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (s_axis_tvalid),
    .ready_o      (s_axis_tready),
    .func_i       (s_axis_tdata[2:0]),
    .tbyte_i      (s_axis_tdata[10:3]),
    .motor_i      (s_axis_tdata[11]),
    .item_valid_o (item_valid),
    .item_o       (item),
    .pop_i        (pop)
  );

  // execute commands, hold the result until taken
  tpp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .item_valid_i (item_valid),
    .item_i       (item),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_o        (res),
    .out_ready_i  (m_axis_tready)
  );

  assign m_axis_tdata = {7'd0, res.full, res.stopped, res.playing, res.changed,
                         res.secs, res.head, res.fall, res.rise};

endmodule
`default_nettype wire

// ===== rtl/tpp_checker.sv =====
`default_nettype none
module tpp_assert (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [47:0] m_axis_tdata
);

  // hold a stalled beat
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat changed while stalled");

  a_one_edge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
    else $error("rise and fall on one tick");

  a_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[39] |-> m_axis_tdata[1] && !m_axis_tdata[38])
    else $error("auto stop without fall or with play held");

  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[40] |->
      !m_axis_tdata[0] && !m_axis_tdata[1] && !m_axis_tdata[39])
    else $error("store full on a tick result");

endmodule

bind tape_pulse_playback tpp_assert u_tpp_assert (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
